>>> sv/fidd_pkg.sv
// Shared types, constants and the CRC-32 byte update for the image download deframer.
`default_nettype none

package fidd_pkg;

    localparam logic [31:0] HDR_MAGIC = 32'h314C_4451;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [3:0]  HDR_LAST  = 4'd11;

    localparam int QDEPTH  = 4;
    localparam int QADDR_W = 2;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_ENDED   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EV_WRITE   = 2'd0,
        EV_HDR_OK  = 2'd1,
        EV_DONE_OK = 2'd2,
        EV_ERROR   = 2'd3
    } ev_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_BASE  = 3'd1,
        ERR_BAD_HDR   = 3'd2,
        ERR_TOO_LARGE = 3'd3,
        ERR_CRC       = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        OP_ERROR  = 2'd0,
        OP_HDR_OK = 2'd1,
        OP_WRITE  = 2'd2
    } op_kind_t;

    // One classified operation handed from the front end to the back end.
    typedef struct packed {
        op_kind_t    kind;
        err_t        code;
        logic [24:0] address;
        logic [7:0]  data_byte;
        logic [23:0] bytes_done;
        logic        progress;
        logic        fin;
        logic [31:0] expected;
        logic [23:0] size;
    } op_t;

    typedef struct packed {
        ev_t         kind;
        err_t        code;
        logic [24:0] address;
        logic [7:0]  data_byte;
        logic [23:0] bytes_done;
        logic        progress_mark;
        logic        last_of_run;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Reflected CRC-32, one byte folded in.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/fidd_ifs.sv
// Channel interfaces: input item, result and base address write.
`default_nettype none

interface fidd_item_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface fidd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [2:0]  error_code;
    logic [24:0] address;
    logic [7:0]  data_byte;
    logic [23:0] bytes_done;
    logic        progress_mark;
    logic        last_of_run;

    modport source (output valid, output event_kind, output error_code, output address,
                    output data_byte, output bytes_done, output progress_mark,
                    output last_of_run, input ready);
    modport sink (input valid, input event_kind, input error_code, input address,
                  input data_byte, input bytes_done, input progress_mark,
                  input last_of_run, output ready);
endinterface

interface fidd_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] base_address;

    modport source (output valid, output base_address, input ready);
    modport sink (input valid, input base_address, output ready);
endinterface

`default_nettype wire

>>> sv/fidd_front.sv
// Front end: session state, header parsing and classification of each input beat.
`default_nettype none

module fidd_front #(
    parameter int FLASH_BYTES   = 8388608,
    parameter int SECTOR_BYTES  = 4096,
    parameter int PROGRESS_STEP = 1048576
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    fidd_item_if.sink              item,
    input  wire logic [23:0]       base_address,
    input  wire fidd_pkg::q_stat_t q_stat,
    output fidd_pkg::op_t          push_op,
    output logic                   push
);
    import fidd_pkg::*;

    localparam int PW = $clog2(PROGRESS_STEP);
    localparam logic [32:0] FLASH_L  = 33'(FLASH_BYTES);
    localparam logic [32:0] SEC_M1   = 33'(SECTOR_BYTES - 1);
    localparam logic [PW-1:0] PROG_LAST = PW'(PROGRESS_STEP - 1);

    phase_t        phase_reg, phase_next;
    logic [3:0]    hdr_cnt_reg, hdr_cnt_next;
    logic [31:0]   magic_reg, magic_next;
    logic [31:0]   size_reg, size_next;
    logic [31:0]   expect_reg, expect_next;
    logic [23:0]   addr_reg, addr_next;
    logic [23:0]   written_reg, written_next;
    logic [PW-1:0] prog_cnt_reg, prog_cnt_next;

    logic          accept;
    logic [31:0]   shifted;
    logic [32:0]   end_sum;
    logic [32:0]   end_rounded;
    logic [23:0]   done;
    logic          fin;
    logic          step_hit;

    assign item.ready = !q_stat.full;
    assign accept     = item.valid && item.ready;

    assign shifted     = {24'd0, item.rx_byte} << {hdr_cnt_reg[1:0], 3'b000};
    assign end_sum     = {9'd0, addr_reg} + {1'b0, size_reg};
    // Sector size is a power of two, so rounding up is an add and a mask.
    assign end_rounded = (end_sum + SEC_M1) & ~SEC_M1;
    assign done        = written_reg + 24'd1;
    assign fin         = {8'd0, done} >= size_reg;
    assign step_hit    = prog_cnt_reg == PROG_LAST;

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        magic_next    = magic_reg;
        size_next     = size_reg;
        expect_next   = expect_reg;
        addr_next     = addr_reg;
        written_next  = written_reg;
        prog_cnt_next = prog_cnt_reg;
        push          = 1'b0;
        push_op       = '0;
        push_op.code  = ERR_NONE;

        if (accept)
        begin
            if (!item.command)
            begin
                hdr_cnt_next  = '0;
                magic_next    = '0;
                size_next     = '0;
                expect_next   = '0;
                written_next  = '0;
                prog_cnt_next = '0;
                if ({1'b0, base_address} >= 25'(FLASH_BYTES))
                begin
                    addr_next    = '0;
                    phase_next   = PH_ENDED;
                    push         = 1'b1;
                    push_op.kind = OP_ERROR;
                    push_op.code = ERR_BAD_BASE;
                end
                else
                begin
                    addr_next  = base_address;
                    phase_next = PH_HEADER;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        hdr_cnt_next = hdr_cnt_reg + 4'd1;
                        case (hdr_cnt_reg[3:2])
                            2'd0:    magic_next  = magic_reg | shifted;
                            2'd1:    size_next   = size_reg | shifted;
                            default: expect_next = expect_reg | shifted;
                        endcase
                        // Magic and size are complete by the last header beat.
                        if (hdr_cnt_reg == HDR_LAST)
                        begin
                            push       = 1'b1;
                            phase_next = PH_ENDED;
                            if (magic_reg != HDR_MAGIC || size_reg == 32'd0)
                            begin
                                push_op.kind = OP_ERROR;
                                push_op.code = ERR_BAD_HDR;
                            end
                            else if (end_sum > FLASH_L)
                            begin
                                push_op.kind = OP_ERROR;
                                push_op.code = ERR_TOO_LARGE;
                            end
                            else
                            begin
                                phase_next      = PH_PAYLOAD;
                                written_next    = '0;
                                prog_cnt_next   = '0;
                                push_op.kind    = OP_HDR_OK;
                                push_op.address = end_rounded[24:0];
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        push               = 1'b1;
                        push_op.kind       = OP_WRITE;
                        push_op.address    = {1'b0, addr_reg};
                        push_op.data_byte  = item.rx_byte;
                        push_op.bytes_done = done;
                        push_op.progress   = step_hit || fin;
                        push_op.fin        = fin;
                        push_op.expected   = expect_reg;
                        push_op.size       = size_reg[23:0];
                        addr_next          = addr_reg + 24'd1;
                        written_next       = done;
                        prog_cnt_next      = step_hit ? '0 : prog_cnt_reg + PW'(1);
                        if (fin)
                        begin
                            phase_next = PH_ENDED;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            hdr_cnt_reg  <= '0;
            magic_reg    <= '0;
            size_reg     <= '0;
            expect_reg   <= '0;
            addr_reg     <= '0;
            written_reg  <= '0;
            prog_cnt_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            magic_reg    <= magic_next;
            size_reg     <= size_next;
            expect_reg   <= expect_next;
            addr_reg     <= addr_next;
            written_reg  <= written_next;
            prog_cnt_reg <= prog_cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/fidd_fifo.sv
// Short operation queue between the front end and the back end.
`default_nettype none

module fidd_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire fidd_pkg::op_t     push_op,
    input  wire logic              pop,
    output fidd_pkg::op_t          pop_op,
    output fidd_pkg::q_stat_t      q_stat
);
    import fidd_pkg::*;

    op_t                slot_reg [QDEPTH];
    logic [QADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QADDR_W:0]   count_reg, count_next;

    assign q_stat.full  = count_reg == (QADDR_W + 1)'(QDEPTH);
    assign q_stat.empty = count_reg == '0;
    assign pop_op       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QADDR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QADDR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (QADDR_W + 1)'(push) - (QADDR_W + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !pop)
        else $error("queue read while empty");

endmodule

`default_nettype wire

>>> sv/fidd_back.sv
// Back end: CRC-32 accumulation and result generation with an output register.
`default_nettype none

module fidd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fidd_pkg::op_t     q_op,
    input  wire fidd_pkg::q_stat_t q_stat,
    output logic                   q_pop,
    fidd_result_if.source          result
);
    import fidd_pkg::*;

    logic        out_valid_reg, out_valid_next;
    res_t        out_reg, out_next;
    logic        pend_valid_reg, pend_valid_next;
    res_t        pend_reg, pend_next;
    logic [31:0] crc_reg, crc_next;

    logic        load;
    logic [31:0] crc_upd;
    res_t        op_res;
    res_t        end_res;

    assign load    = !out_valid_reg || result.ready;
    assign q_pop   = load && !pend_valid_reg && !q_stat.empty;
    assign crc_upd = crc_byte(crc_reg, q_op.data_byte);

    always_comb
    begin
        op_res             = '0;
        op_res.code        = q_op.code;
        op_res.last_of_run = 1'b1;
        case (q_op.kind)
            OP_ERROR:  op_res.kind = EV_ERROR;
            OP_HDR_OK:
            begin
                op_res.kind    = EV_HDR_OK;
                op_res.address = q_op.address;
            end
            OP_WRITE:
            begin
                op_res.kind          = EV_WRITE;
                op_res.address       = q_op.address;
                op_res.data_byte     = q_op.data_byte;
                op_res.bytes_done    = q_op.bytes_done;
                op_res.progress_mark = q_op.progress;
                op_res.last_of_run   = !q_op.fin;
            end
            default:   op_res.kind = EV_ERROR;
        endcase

        // Session result that follows the last payload write.
        end_res             = '0;
        end_res.bytes_done  = q_op.size;
        end_res.last_of_run = 1'b1;
        if ((crc_upd ^ CRC_INIT) == q_op.expected)
        begin
            end_res.kind = EV_DONE_OK;
            end_res.code = ERR_NONE;
        end
        else
        begin
            end_res.kind = EV_ERROR;
            end_res.code = ERR_CRC;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        crc_next        = crc_reg;

        if (load)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
            end
            else if (!q_stat.empty)
            begin
                out_valid_next = 1'b1;
                out_next       = op_res;
                case (q_op.kind)
                    OP_HDR_OK: crc_next = CRC_INIT;
                    OP_WRITE:
                    begin
                        crc_next = crc_upd;
                        if (q_op.fin)
                        begin
                            pend_valid_next = 1'b1;
                            pend_next       = end_res;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            crc_reg        <= CRC_INIT;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            crc_reg        <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.event_kind    = out_reg.kind;
    assign result.error_code    = out_reg.code;
    assign result.address       = out_reg.address;
    assign result.data_byte     = out_reg.data_byte;
    assign result.bytes_done    = out_reg.bytes_done;
    assign result.progress_mark = out_reg.progress_mark;
    assign result.last_of_run   = out_reg.last_of_run;

    a_pend_behind_write: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg && out_reg.kind == EV_WRITE && !out_reg.last_of_run)
        else $error("session result pending without its final write in the output");

    a_no_pop_while_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !q_pop)
        else $error("queue popped while a session result is pending");

    a_pend_follows: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && result.ready |=> out_valid_reg && out_reg.last_of_run
            && (out_reg.kind == EV_DONE_OK || out_reg.kind == EV_ERROR))
        else $error("session result did not follow the final write");

endmodule

`default_nettype wire

>>> sv/flash_image_download_deframer.sv
// Top level of the CRC-32 checked flash image download deframer.
//
//  channel  | dir | beat carries                               | accepted when
//  ---------+-----+--------------------------------------------+-------------------
//  item     | in  | command, rx_byte                           | valid && ready
//  result   | out | event_kind, error_code, address, data_byte,| valid && ready
//           |     | bytes_done, progress_mark, last_of_run     |
//  cfg      | in  | base_address                               | valid (ready high)
//
// One item per cycle is taken while the queue is not full; a result is registered at
// the edge where its operation leaves the queue, so with nothing ahead of it a result
// passes a queue slot and then the output register. A final payload byte gives two
// results, which the four-entry operation queue between front and back absorbs.
// Reset clears all control state at once; there is no clearing pass.
// The item channel stalls only when the queue is full; a result stall backs up the queue.
`default_nettype none

module flash_image_download_deframer #(
    parameter int FLASH_BYTES   = 8388608,
    parameter int SECTOR_BYTES  = 4096,
    parameter int PROGRESS_STEP = 1048576
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    fidd_item_if.sink     item,
    fidd_result_if.source result,
    fidd_cfg_if.sink      cfg
);
    import fidd_pkg::*;

    logic [23:0] base_reg;
    op_t         push_op;
    logic        push;
    op_t         q_op;
    logic        q_pop;
    q_stat_t     q_stat;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg.valid)
        begin
            base_reg <= cfg.base_address;
        end
    end

    fidd_front #(
        .FLASH_BYTES   (FLASH_BYTES),
        .SECTOR_BYTES  (SECTOR_BYTES),
        .PROGRESS_STEP (PROGRESS_STEP)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .base_address (base_reg),
        .q_stat       (q_stat),
        .push_op      (push_op),
        .push         (push)
    );

    fidd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (q_pop),
        .pop_op  (q_op),
        .q_stat  (q_stat)
    );

    fidd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_op   (q_op),
        .q_stat (q_stat),
        .q_pop  (q_pop),
        .result (result)
    );

endmodule

`default_nettype wire

>>> verif/flash_image_download_deframer_checker.sv
// Testbench command codes and the scoreboard that predicts and checks the deframer's results.
`timescale 1ns / 100ps

package fidd_tb_pkg;
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;
endpackage

module flash_image_download_deframer_checker #(
    parameter int FLASH_BYTES   = 8388608,
    parameter int SECTOR_BYTES  = 4096,
    parameter int PROGRESS_STEP = 1048576
) (
    input  logic   clk,
    input  logic   rst_n,
    fidd_item_if   item,
    fidd_result_if result,
    fidd_cfg_if    cfg,
    output int     failures,
    output int     pending
);
    import fidd_pkg::*;
    import fidd_tb_pkg::*;

    logic [23:0] base_reg;
    phase_t      phase;
    logic [3:0]  hdr_cnt;
    logic [31:0] magic_w;
    logic [31:0] size_w;
    logic [31:0] want_crc;
    logic [31:0] crc_acc;
    logic [23:0] wr_addr;
    logic [23:0] wr_count;
    res_t        expected_q[$];
    int          fail_count = 0;

    function automatic logic [31:0] crc_fold(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc ^ {24'd0, b};
        repeat (8) c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        return c;
    endfunction

    function automatic res_t make_result(input ev_t kind, input err_t code,
                                         input logic [24:0] addr, input logic [7:0] data,
                                         input logic [23:0] done, input logic prog,
                                         input logic last);
        res_t r;
        r.kind          = kind;
        r.code          = code;
        r.address       = addr;
        r.data_byte     = data;
        r.bytes_done    = done;
        r.progress_mark = prog;
        r.last_of_run   = last;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [24:0] want,
                                 input logic [24:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Advances the download state by one beat and queues the results it must cause.
    task automatic predict(input logic cmd, input logic [7:0] b);
        logic [31:0]     done_n;
        longint unsigned span;
        longint unsigned erase_end;
        logic            fin;
        logic            prog;
        if (cmd == CMD_START)
        begin
            hdr_cnt  = '0;
            magic_w  = '0;
            size_w   = '0;
            want_crc = '0;
            crc_acc  = CRC_INIT;
            wr_count = '0;
            if ({8'd0, base_reg} >= FLASH_BYTES)
            begin
                wr_addr = '0;
                phase   = PH_ENDED;
                expected_q.push_back(make_result(EV_ERROR, ERR_BAD_BASE, '0, '0, '0, 1'b0, 1'b1));
            end
            else
            begin
                wr_addr = base_reg;
                phase   = PH_HEADER;
            end
        end
        else if (phase == PH_HEADER)
        begin
            // Little-endian words: each new byte enters at the top and slides down.
            if (hdr_cnt < 4)
                magic_w = {b, magic_w[31:8]};
            else if (hdr_cnt < 8)
                size_w = {b, size_w[31:8]};
            else
                want_crc = {b, want_crc[31:8]};
            hdr_cnt++;
            if (hdr_cnt == 4'd12)
            begin
                span = {40'd0, wr_addr} + {32'd0, size_w};
                if (magic_w != HDR_MAGIC || size_w == 0)
                begin
                    phase = PH_ENDED;
                    expected_q.push_back(make_result(EV_ERROR, ERR_BAD_HDR, '0, '0, '0,
                                                     1'b0, 1'b1));
                end
                else if (span > FLASH_BYTES)
                begin
                    phase = PH_ENDED;
                    expected_q.push_back(make_result(EV_ERROR, ERR_TOO_LARGE, '0, '0, '0,
                                                     1'b0, 1'b1));
                end
                else
                begin
                    erase_end = ((span + SECTOR_BYTES - 1) / SECTOR_BYTES) * SECTOR_BYTES;
                    phase     = PH_PAYLOAD;
                    wr_count  = '0;
                    crc_acc   = CRC_INIT;
                    expected_q.push_back(make_result(EV_HDR_OK, ERR_NONE, erase_end[24:0], '0,
                                                     '0, 1'b0, 1'b1));
                end
            end
        end
        else if (phase == PH_PAYLOAD)
        begin
            done_n  = {8'd0, wr_count} + 32'd1;
            fin     = (done_n >= size_w);
            prog    = ((done_n % PROGRESS_STEP) == 0) || fin;
            crc_acc = crc_fold(crc_acc, b);
            expected_q.push_back(make_result(EV_WRITE, ERR_NONE, {1'b0, wr_addr}, b,
                                             done_n[23:0], prog, !fin));
            wr_addr  = wr_addr + 24'd1;
            wr_count = done_n[23:0];
            if (fin)
            begin
                phase = PH_ENDED;
                if (~crc_acc == want_crc)
                    expected_q.push_back(make_result(EV_DONE_OK, ERR_NONE, '0, '0,
                                                     size_w[23:0], 1'b0, 1'b1));
                else
                    expected_q.push_back(make_result(EV_ERROR, ERR_CRC, '0, '0,
                                                     size_w[23:0], 1'b0, 1'b1));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            base_reg = '0;
            phase    = PH_IDLE;
            hdr_cnt  = '0;
            magic_w  = '0;
            size_w   = '0;
            want_crc = '0;
            crc_acc  = CRC_INIT;
            wr_addr  = '0;
            wr_count = '0;
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            // Results are checked before this edge's beat is predicted, so a result
            // arriving with nothing queued is never hidden by a new expectation.
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got kind %0d code %0d",
                             $time, result.event_kind, result.error_code);
                    $display("%0t:   address 0x%0h data 0x%0h done %0d progress %0b last %0b",
                             $time, result.address, result.data_byte, result.bytes_done,
                             result.progress_mark, result.last_of_run);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("event_kind", 25'(want.kind), 25'(result.event_kind));
                    compare_field("error_code", 25'(want.code), 25'(result.error_code));
                    compare_field("address", want.address, result.address);
                    compare_field("data_byte", 25'(want.data_byte), 25'(result.data_byte));
                    compare_field("bytes_done", 25'(want.bytes_done), 25'(result.bytes_done));
                    compare_field("progress_mark", 25'(want.progress_mark),
                                  25'(result.progress_mark));
                    compare_field("last_of_run", 25'(want.last_of_run),
                                  25'(result.last_of_run));
                end
            end
            if (item.valid && item.ready)
                predict(item.command, item.rx_byte);
            if (cfg.valid && cfg.ready)
                base_reg = cfg.base_address;
            pending <= expected_q.size();
        end
        failures <= fail_count;
    end

endmodule

>>> verif/flash_image_download_deframer_tb.sv
// Testbench top: drives the deframer's byte and base address channels and gives the verdict.
`timescale 1ns / 100ps

module flash_image_download_deframer_tb;
    import fidd_pkg::*;
    import fidd_tb_pkg::*;

    localparam int FLASH_BYTES   = 8388608;
    localparam int SECTOR_BYTES  = 4096;
    localparam int PROGRESS_STEP = 1048576;
    localparam int ITEM_TARGET   = 1100;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;

    logic        clk;
    logic        rst_n;
    int          failures;
    int          pending_results;
    int          cycle_count = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          useful_items = 0;
    logic [23:0] cur_base;

    fidd_item_if   item_ch ();
    fidd_result_if result_ch ();
    fidd_cfg_if    cfg_ch ();

    flash_image_download_deframer #(
        .FLASH_BYTES   (FLASH_BYTES),
        .SECTOR_BYTES  (SECTOR_BYTES),
        .PROGRESS_STEP (PROGRESS_STEP)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    flash_image_download_deframer_checker #(
        .FLASH_BYTES   (FLASH_BYTES),
        .SECTOR_BYTES  (SECTOR_BYTES),
        .PROGRESS_STEP (PROGRESS_STEP)
    ) chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_ch),
        .result   (result_ch),
        .cfg      (cfg_ch),
        .failures (failures),
        .pending  (pending_results)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result receiver: stalls at random with the current idle percentage.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic logic [31:0] image_crc(input logic [7:0] body[$],
                                              input logic [31:0] limit);
        logic [31:0] c;
        c = CRC_INIT;
        foreach (body[i])
        begin
            if (i < limit)
            begin
                c = c ^ {24'd0, body[i]};
                repeat (8) c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
            end
        end
        return ~c;
    endfunction

    // One beat on the byte channel; valid stays high afterwards until the next call
    // or until the sender goes quiet.
    task automatic send_item(input logic cmd, input logic [7:0] b, input bit useful);
        while ($urandom_range(99) < send_idle)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.command <= cmd;
        item_ch.rx_byte <= b;
        do @(posedge clk); while (!item_ch.ready);
        if (useful)
            useful_items++;
    endtask

    // Stops sending and waits until every queued result is out and the pipe is empty.
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(input logic [23:0] value);
        settle();
        cfg_ch.valid        <= 1'b1;
        cfg_ch.base_address <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_base = value;
    endtask

    // An optional start, the first hdr_len header bytes, then body_len payload bytes. The header CRC
    // covers the bytes up to the declared size and is corrupted on request.
    task automatic run_session(input bit with_start, input logic [31:0] magic,
                               input logic [31:0] size_field, input int hdr_len,
                               input int body_len, input bit bad_crc);
        logic [7:0]  body[$];
        logic [95:0] hdr;
        logic [31:0] crc;
        for (int i = 0; i < body_len; i++)
            body.push_back(8'($urandom));
        crc = image_crc(body, size_field);
        if (bad_crc)
            crc = crc ^ (32'h1 << $urandom_range(31));
        hdr = {crc, size_field, magic};
        if (with_start)
            send_item(CMD_START, 8'($urandom), 1'b1);
        for (int i = 0; i < hdr_len; i++)
            send_item(CMD_BYTE, hdr[8*i +: 8], 1'b1);
        foreach (body[i])
            send_item(CMD_BYTE, body[i], i < size_field);
    endtask

    initial
    begin
        int          room;
        int          sz;
        int          body_len;
        int          pick;
        int          base_pick;
        logic [31:0] big;
        logic [23:0] new_base;
        logic        noise_cmd;
        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.command      = CMD_START;
        item_ch.rx_byte      = 8'h00;
        cfg_ch.valid         = 1'b0;
        cfg_ch.base_address  = 24'h000000;
        cur_base             = 24'h000000;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // A byte before any session is ignored.
        send_item(CMD_BYTE, 8'hFF, 1'b1);
        // First base beyond flash: the start fails and the next byte is ignored.
        write_base(24'(FLASH_BYTES));
        send_item(CMD_START, 8'h00, 1'b1);
        send_item(CMD_BYTE, 8'h00, 1'b1);
        // One byte image at the very last flash byte; the base is rewritten after the
        // start, and the latched one must still be used.
        write_base(24'(FLASH_BYTES - 1));
        send_item(CMD_START, 8'hFF, 1'b1);
        write_base(24'h000000);
        run_session(1'b0, HDR_MAGIC, 32'd1, 12, 1, 1'b0);
        write_base(24'hFFFFFF);
        send_item(CMD_START, 8'hA5, 1'b1);

        write_base(24'h000000);
        useful_items = 0;
        for (int stage = 0; stage < 3; stage++)
        begin
            send_idle = (stage == 0) ? 24 : (stage == 1) ? 62 : 0;
            recv_idle = (stage == 0) ? 62 : (stage == 1) ? 24 : 0;
            while (useful_items < (stage + 1) * ITEM_TARGET / 3)
            begin
                room = FLASH_BYTES - int'(cur_base);
                sz = ($urandom_range(19) == 0) ? int'($urandom_range(400, 64))
                                               : int'($urandom_range(24, 1));
                if (sz > room)
                    sz = room;
                pick = $urandom_range(99);
                if (pick < 52)
                    run_session(1'b1, HDR_MAGIC, 32'(sz), 12, sz, 1'b0);
                else if (pick < 60)
                    run_session(1'b1, HDR_MAGIC, 32'(sz), 12, sz, 1'b1);
                else if (pick < 65)
                    run_session(1'b1, HDR_MAGIC ^ (32'h1 << $urandom_range(31)), 32'(sz), 12,
                                $urandom_range(3), 1'b0);
                else if (pick < 68)
                    run_session(1'b1, HDR_MAGIC, 32'd0, 12, $urandom_range(2), 1'b0);
                else if (pick < 72)
                begin
                    big = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF
                                                   : 32'(room) + 32'd1 + $urandom_range(4095);
                    run_session(1'b1, HDR_MAGIC, big, 12, 1, 1'b0);
                end
                else if (pick < 78)
                begin
                    // Large declared size cut short; the next start abandons it.
                    big = 32'($urandom_range(room, 1));
                    body_len = $urandom_range(15);
                    if (body_len >= int'(big))
                        body_len = int'(big) - 1;
                    run_session(1'b1, HDR_MAGIC, big, 12, body_len, 1'b0);
                end
                else if (pick < 82)
                    run_session(1'b1, HDR_MAGIC, 32'(sz), $urandom_range(11), 0, 1'b0);
                else if (pick < 87)
                    run_session(1'b1, HDR_MAGIC, 32'(sz), 12, sz + int'($urandom_range(4, 1)),
                                $urandom_range(1));
                else if (pick < 91)
                begin
                    repeat ($urandom_range(4, 1))
                    begin
                        noise_cmd = $urandom_range(1);
                        send_item(noise_cmd, 8'($urandom), noise_cmd == CMD_START);
                    end
                end
                else if (pick < 93)
                    settle();
                else
                begin
                    base_pick = $urandom_range(9);
                    if (base_pick == 0)
                        new_base = 24'h000000;
                    else if (base_pick == 1)
                        new_base = 24'(FLASH_BYTES - 1);
                    else if (base_pick == 2)
                        new_base = 24'(FLASH_BYTES + $urandom_range(FLASH_BYTES - 1));
                    else if (base_pick == 3)
                        new_base = 24'(FLASH_BYTES - int'($urandom_range(64, 1)));
                    else
                        new_base = 24'($urandom_range(FLASH_BYTES - 1));
                    if (base_pick == 2)
                    begin
                        write_base(new_base);
                        run_session(1'b1, HDR_MAGIC, 32'd1, 12, 1, 1'b0);
                        write_base(24'($urandom_range(FLASH_BYTES - 1)));
                    end
                    else if ($urandom_range(1) == 0)
                    begin
                        // Rebase while a session is open; sz still fits the old base.
                        send_item(CMD_START, 8'($urandom), 1'b1);
                        write_base(new_base);
                        run_session(1'b0, HDR_MAGIC, 32'(sz), 12, sz, 1'b0);
                    end
                    else
                        write_base(new_base);
                end
            end
        end

        settle();
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> flash_image_download_deframer.f
sv/fidd_pkg.sv
sv/fidd_ifs.sv
sv/fidd_front.sv
sv/fidd_fifo.sv
sv/fidd_back.sv
sv/flash_image_download_deframer.sv
verif/flash_image_download_deframer_checker.sv
verif/flash_image_download_deframer_tb.sv
